// ===== src/ascp_pkg.sv =====
// ----------------------------------------------------------------------------
// ascp_pkg
// Shared constants and types for the audio sample cleanup and packer block.
// ----------------------------------------------------------------------------
package ascp_pkg;

   // Sample and converter word layout
   localparam int RAW_W    = 16;
   localparam int SAMPLE_W = 12;
   localparam int TAG_W    = 4;
   localparam int PACKED_W = 2 * SAMPLE_W;

   // Averaging window
   localparam int WINDOW_TAPS = 3;
   localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW_TAPS);

   // Floor division of the window sum by the tap count:
   // q = (sum * DIV_RECIP) >> DIV_SHIFT, exact for every sum below 2**SUM_W.
   localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_TAPS);
   localparam int DIV_RECIP = ((2 ** DIV_SHIFT) + WINDOW_TAPS - 1) / WINDOW_TAPS;
   localparam int RECIP_W   = SUM_W + 2;
   localparam int PROD_W    = SUM_W + RECIP_W;

   // Control/status register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SAMPLE_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIDPOINT   = 2'd0,
      CSR_DEV_LIMIT  = 2'd1,
      CSR_HEADER_TAG = 2'd2
   } csr_idx_type;

   // Reset values
   localparam logic [SAMPLE_W-1:0] MIDPOINT_RESET   = 12'd2048;
   localparam logic [SAMPLE_W-1:0] DEV_LIMIT_RESET  = 12'd700;
   localparam logic [TAG_W-1:0]    HEADER_TAG_RESET = 4'd10;
   localparam logic [SAMPLE_W-1:0] GOOD_RESET       = 12'd2048;

endpackage

// ===== src/ascp_req_if.sv =====
// ----------------------------------------------------------------------------
// ascp_req_if
// Input channel: a pair of raw converter words and the recording flag.
// ----------------------------------------------------------------------------
interface ascp_req_if;
   logic                          valid;
   logic                          ready;
   logic [ascp_pkg::RAW_W-1:0]    raw_first;
   logic [ascp_pkg::RAW_W-1:0]    raw_second;
   logic                          recording;

   modport source (output valid, output raw_first, output raw_second,
                   output recording, input ready);
   modport sink   (input valid, input raw_first, input raw_second,
                   input recording, output ready);
endinterface

// ===== src/ascp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ascp_rsp_if
// Result channel: the packed pair of filtered samples.
// ----------------------------------------------------------------------------
interface ascp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ascp_pkg::PACKED_W-1:0] packed_pair;

   modport source (output valid, output packed_pair, input ready);
   modport sink   (input valid, input packed_pair, output ready);
endinterface

// ===== src/ascp_csr_if.sv =====
// ----------------------------------------------------------------------------
// ascp_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ascp_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ascp_pkg::CSR_IDX_W-1:0]  reg_index;
   logic [ascp_pkg::CSR_DATA_W-1:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== src/audio_sample_cleanup_packer_top.sv =====
// ----------------------------------------------------------------------------
// audio_sample_cleanup_packer_top
// Tag check, outlier reject, running-sum average and packing of sample pairs.
// ----------------------------------------------------------------------------
//  channel   | dir | transfer payload
//  ----------+-----+----------------------------------------------
//  req_chan  | in  | raw_first[15:0], raw_second[15:0], recording
//  rsp_chan  | out | packed_pair[23:0]
//  csr_chan  | in  | reg_index[1:0], wr_data[11:0]
//
//  One pair per cycle sustained while results are taken; a pair passes the
//  input register, then the result register, the whole pair path in between.
//  Pairs with recording low are consumed with no result and no state change.
//  Synchronous active-high reset restores the register and filter defaults.
//  A stalled result holds the pipe; one more pair is held in the input stage.
//  Register writes are always taken (ready tied high).
// ----------------------------------------------------------------------------
module audio_sample_cleanup_packer_top (
   input  logic        clock,
   input  logic        reset,
   ascp_req_if.sink    req_chan,
   ascp_rsp_if.source  rsp_chan,
   ascp_csr_if.sink    csr_chan
);

   localparam int SW = ascp_pkg::SAMPLE_W;
   localparam int NT = ascp_pkg::WINDOW_TAPS;
   localparam int SM = ascp_pkg::SUM_W;

   localparam logic [ascp_pkg::RECIP_W-1:0] RECIP =
      ascp_pkg::RECIP_W'(ascp_pkg::DIV_RECIP);

   // Configuration registers
   logic [SW-1:0]               midpoint_ff;
   logic [SW-1:0]               dev_limit_ff;
   logic [ascp_pkg::TAG_W-1:0]  tag_ff;

   // Input stage
   logic                        in_valid_ff, in_valid_in;
   logic [ascp_pkg::RAW_W-1:0]  in_first_ff, in_second_ff;
   logic                        in_rec_ff;

   // Filter state
   logic [SW-1:0]               good_first_ff, good_first_in;
   logic [SW-1:0]               good_second_ff, good_second_in;
   logic [SW-1:0]               lir_ff, lir_in;
   logic [SW-1:0]               taps_ff [NT];
   logic [SW-1:0]               taps_in [NT];
   logic [SM-1:0]               sum_ff, sum_in;

   // Result stage
   logic                        out_valid_ff, out_valid_in;
   logic [ascp_pkg::PACKED_W-1:0] out_data_ff, out_data_in;

   logic                        advance;
   logic                        req_xfer;
   logic                        process;

   logic [SW-1:0]               samp_a, samp_b;
   logic [SW-1:0]               dist_a, dist_b;
   logic [SW-1:0]               clean_a, clean_b;
   logic [SW-1:0]               lir_mid;
   logic [SM-1:0]               sum_a, sum_b;
   logic [ascp_pkg::PROD_W-1:0] prod_a, prod_b;
   logic [SW-1:0]               avg_a, avg_b;

   assign advance          = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready   = !in_valid_ff || advance;
   assign req_xfer         = req_chan.valid && req_chan.ready;
   assign process          = in_valid_ff && in_rec_ff && advance;

   assign csr_chan.ready   = 1'b1;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.packed_pair = out_data_ff;

   always_comb begin
      // Tag check: a mismatched word repeats the channel's last good sample
      samp_a = (in_first_ff[ascp_pkg::RAW_W-1 -: ascp_pkg::TAG_W] == tag_ff)
               ? in_first_ff[SW-1:0] : good_first_ff;
      samp_b = (in_second_ff[ascp_pkg::RAW_W-1 -: ascp_pkg::TAG_W] == tag_ff)
               ? in_second_ff[SW-1:0] : good_second_ff;

      // Outlier reject, first sample feeds the hold value seen by the second
      dist_a  = (samp_a >= midpoint_ff) ? (samp_a - midpoint_ff)
                                        : (midpoint_ff - samp_a);
      lir_mid = (dist_a > dev_limit_ff) ? lir_ff : samp_a;
      clean_a = lir_mid;
      dist_b  = (samp_b >= midpoint_ff) ? (samp_b - midpoint_ff)
                                        : (midpoint_ff - samp_b);
      clean_b = (dist_b > dev_limit_ff) ? lir_mid : samp_b;

      // Running sum: each push drops the oldest tap
      sum_a = sum_ff - SM'(taps_ff[NT-1]) + SM'(clean_a);
      sum_b = sum_a - SM'(taps_ff[NT-2]) + SM'(clean_b);

      prod_a = ascp_pkg::PROD_W'(sum_a) * ascp_pkg::PROD_W'(RECIP);
      prod_b = ascp_pkg::PROD_W'(sum_b) * ascp_pkg::PROD_W'(RECIP);
      avg_a  = prod_a[ascp_pkg::DIV_SHIFT +: SW];
      avg_b  = prod_b[ascp_pkg::DIV_SHIFT +: SW];

      good_first_in  = good_first_ff;
      good_second_in = good_second_ff;
      lir_in         = lir_ff;
      sum_in         = sum_ff;
      taps_in        = taps_ff;
      out_data_in    = out_data_ff;
      if (process) begin
         good_first_in  = samp_a;
         good_second_in = samp_b;
         lir_in         = clean_b;
         sum_in         = sum_b;
         taps_in[0]     = clean_b;
         taps_in[1]     = clean_a;
         for (int i = 2; i < NT; i++) begin
            taps_in[i] = taps_ff[i-2];
         end
         out_data_in    = {avg_a, avg_b};
      end

      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = in_valid_ff && in_rec_ff;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         midpoint_ff    <= ascp_pkg::MIDPOINT_RESET;
         dev_limit_ff   <= ascp_pkg::DEV_LIMIT_RESET;
         tag_ff         <= ascp_pkg::HEADER_TAG_RESET;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         good_first_ff  <= ascp_pkg::GOOD_RESET;
         good_second_ff <= ascp_pkg::GOOD_RESET;
         lir_ff         <= ascp_pkg::GOOD_RESET;
         sum_ff         <= '0;
         for (int i = 0; i < NT; i++) begin
            taps_ff[i] <= '0;
         end
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         good_first_ff  <= good_first_in;
         good_second_ff <= good_second_in;
         lir_ff         <= lir_in;
         sum_ff         <= sum_in;
         taps_ff        <= taps_in;
         if (csr_chan.valid) begin
            unique case (csr_chan.reg_index)
               ascp_pkg::CSR_MIDPOINT:   midpoint_ff  <= csr_chan.wr_data;
               ascp_pkg::CSR_DEV_LIMIT:  dev_limit_ff <= csr_chan.wr_data;
               ascp_pkg::CSR_HEADER_TAG: tag_ff <= csr_chan.wr_data[ascp_pkg::TAG_W-1:0];
               default: ; // unmapped index, write dropped
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_first_ff  <= req_chan.raw_first;
         in_second_ff <= req_chan.raw_second;
         in_rec_ff    <= req_chan.recording;
      end
      out_data_ff <= out_data_in;
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the audio sample cleanup packer against a cycle-free predictor.
// Directed pairs cover tag handling, limit edges, warm-up and ignored pairs;
// random pairs follow under several register settings with random idling,
// one long result stall and drained phase boundaries.
// ----------------------------------------------------------------------------
module testbench;

   localparam int RAW_W       = ascp_pkg::RAW_W;
   localparam int SAMPLE_W    = ascp_pkg::SAMPLE_W;
   localparam int TAG_W       = ascp_pkg::TAG_W;
   localparam int PACKED_W    = ascp_pkg::PACKED_W;
   localparam int WINDOW_TAPS = ascp_pkg::WINDOW_TAPS;
   localparam int SUM_W       = ascp_pkg::SUM_W;
   localparam int CSR_IDX_W   = ascp_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W  = ascp_pkg::CSR_DATA_W;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 2'd3;   // no register here
   localparam int PHASE_PAIRS  = 90;
   localparam int PHASE_COUNT  = 8;
   localparam int DRAIN_CYCLES = 6;
   localparam int LONG_STALL   = 150;
   localparam int MAX_GAP      = 18;
   localparam int REPORT_LIMIT = 10;
   localparam longint RUN_LIMIT_NS = 2_000_000;

   logic clock;
   logic reset;

   ascp_req_if req_chan ();
   ascp_rsp_if rsp_chan ();
   ascp_csr_if csr_chan ();

   audio_sample_cleanup_packer_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   class pair_scoreboard;
      logic [SAMPLE_W-1:0] midpoint;
      logic [SAMPLE_W-1:0] dev_limit;
      logic [TAG_W-1:0]    header_tag;
      logic [SAMPLE_W-1:0] good_first;
      logic [SAMPLE_W-1:0] good_second;
      logic [SAMPLE_W-1:0] last_in_range;
      logic [SAMPLE_W-1:0] taps [WINDOW_TAPS];
      logic [SUM_W-1:0]    window_sum;
      int unsigned         slot;
      logic [PACKED_W-1:0] expected_pairs [$];
      int unsigned         mismatches;
      int unsigned         checked;
      int unsigned         recorded_pairs;
      int unsigned         ignored_pairs;
      int unsigned         reg_writes;

      function new();
         midpoint      = ascp_pkg::MIDPOINT_RESET;
         dev_limit     = ascp_pkg::DEV_LIMIT_RESET;
         header_tag    = ascp_pkg::HEADER_TAG_RESET;
         good_first    = ascp_pkg::GOOD_RESET;
         good_second   = ascp_pkg::GOOD_RESET;
         last_in_range = ascp_pkg::GOOD_RESET;
         foreach (taps[i]) taps[i] = '0;
         window_sum     = '0;
         slot           = 0;
         mismatches     = 0;
         checked        = 0;
         recorded_pairs = 0;
         ignored_pairs  = 0;
         reg_writes     = 0;
      endfunction

      function void apply_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         reg_writes++;
         case (idx)
            ascp_pkg::CSR_MIDPOINT: begin
               midpoint = data[SAMPLE_W-1:0];
            end
            ascp_pkg::CSR_DEV_LIMIT: begin
               dev_limit = data[SAMPLE_W-1:0];
            end
            ascp_pkg::CSR_HEADER_TAG: begin
               header_tag = data[TAG_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // untagged words fall back to the channel's last good sample
      function logic [SAMPLE_W-1:0] take_word(logic [RAW_W-1:0] word,
                                              inout logic [SAMPLE_W-1:0] good);
         if (word[RAW_W-1 -: TAG_W] == header_tag)
            good = word[SAMPLE_W-1:0];
         return good;
      endfunction

      function logic [SAMPLE_W-1:0] reject_outlier(logic [SAMPLE_W-1:0] sample);
         logic [SAMPLE_W-1:0] distance;
         distance = (sample >= midpoint) ? sample - midpoint : midpoint - sample;
         if (distance > dev_limit)
            return last_in_range;
         last_in_range = sample;
         return sample;
      endfunction

      function logic [SAMPLE_W-1:0] push_average(logic [SAMPLE_W-1:0] sample);
         window_sum = window_sum - SUM_W'(taps[slot]) + SUM_W'(sample);
         taps[slot] = sample;
         slot = (slot + 1 == WINDOW_TAPS) ? 0 : slot + 1;
         return SAMPLE_W'(window_sum / WINDOW_TAPS);
      endfunction

      function void note_pair(logic [RAW_W-1:0] raw_first, logic [RAW_W-1:0] raw_second,
                              logic recording);
         logic [SAMPLE_W-1:0] first_out;
         logic [SAMPLE_W-1:0] second_out;
         if (!recording) begin
            ignored_pairs++;
            return;
         end
         recorded_pairs++;
         first_out  = take_word(raw_first, good_first);
         second_out = take_word(raw_second, good_second);
         first_out  = push_average(reject_outlier(first_out));
         second_out = push_average(reject_outlier(second_out));
         expected_pairs.push_back({first_out, second_out});
      endfunction

      function void check_packed(logic [PACKED_W-1:0] actual);
         logic [PACKED_W-1:0] want;
         if (expected_pairs.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected result packed_pair=%06h", $time, actual);
            return;
         end
         want = expected_pairs.pop_front();
         checked++;
         if (actual !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: packed_pair mismatch, expected %06h got %06h",
                        $time, want, actual);
         end
      endfunction
   endclass

   pair_scoreboard sb;
   bit req_idle_on;
   bit rsp_idle_on;
   int stall_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout with %0d results outstanding", sb.expected_pairs.size());
      $display("FAIL");
      $finish;
   end

   function automatic int draw_gap(bit on);
      if (on && $urandom_range(0, 2) != 0)
         return $urandom_range(0, MAX_GAP);
      return 0;
   endfunction

   // mostly tagged words near the midpoint so both reject paths are reached
   function automatic logic [RAW_W-1:0] make_word(logic [SAMPLE_W-1:0] mid,
                                                  logic [SAMPLE_W-1:0] lim,
                                                  logic [TAG_W-1:0] tag);
      int pick;
      int sample;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         sample = int'(mid) - int'(lim) - 2 + $urandom_range(0, 2 * int'(lim) + 4);
         if (sample < 0) sample = 0;
         if (sample > 4095) sample = 4095;
         return {tag, sample[SAMPLE_W-1:0]};
      end
      if (pick < 8)
         return {tag, SAMPLE_W'($urandom)};
      return RAW_W'($urandom);
   endfunction

   // transfers are sampled on pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_packed(rsp_chan.packed_pair);
         if (req_chan.valid && req_chan.ready)
            sb.note_pair(req_chan.raw_first, req_chan.raw_second, req_chan.recording);
         if (csr_chan.valid && csr_chan.ready)
            sb.apply_write(csr_chan.reg_index, csr_chan.wr_data);
      end
   end

   initial begin : result_sink
      int gap;
      forever begin
         gap = draw_gap(rsp_idle_on);
         if (stall_cycles > 0) begin
            gap = stall_cycles;
            stall_cycles = 0;
         end
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid && stall_cycles == 0) @(posedge clock);
      end
   end

   // valid stays high across back-to-back transfers
   task automatic send_pair(logic [RAW_W-1:0] raw_first, logic [RAW_W-1:0] raw_second,
                            logic recording);
      int gap;
      gap = draw_gap(req_idle_on);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.raw_first  <= raw_first;
      req_chan.raw_second <= raw_second;
      req_chan.recording  <= recording;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_chan.valid     <= 1'b1;
      csr_chan.reg_index <= idx;
      csr_chan.wr_data   <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
   endtask

   // drop valid, wait out every result, then let ignored pairs clear the pipe;
   // the first edge lets the last transfer reach the scoreboard
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_pairs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(logic [SAMPLE_W-1:0] mid, logic [SAMPLE_W-1:0] lim,
                                 logic [TAG_W-1:0] tag);
      write_reg(ascp_pkg::CSR_MIDPOINT, mid);
      write_reg(ascp_pkg::CSR_DEV_LIMIT, lim);
      // junk above the tag nibble must be dropped
      write_reg(ascp_pkg::CSR_HEADER_TAG, {CSR_DATA_W'($urandom_range(0, 255)), tag});
      csr_chan.valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [SAMPLE_W-1:0] mid;
      logic [SAMPLE_W-1:0] lim;
      logic [TAG_W-1:0]    tag;
      logic                rec;
      int                  recorded;
      sb = new();
      req_idle_on  = 1'b1;
      rsp_idle_on  = 1'b1;
      stall_cycles = 0;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.raw_first  <= '0;
      req_chan.raw_second <= '0;
      req_chan.recording  <= 1'b0;
      csr_chan.valid      <= 1'b0;
      csr_chan.reg_index  <= ascp_pkg::CSR_MIDPOINT;
      csr_chan.wr_data    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: midpoint 2048, limit 700, tag A
      send_pair(16'h1234, 16'hFFFF, 1'b0);
      send_pair(16'hA800, 16'hA800, 1'b1);
      send_pair(16'hABBC, 16'hA544, 1'b1);   // second word exactly at the limit, first beyond it
      send_pair(16'hABBD, 16'hA543, 1'b1);   // second word one past the limit, first beyond it
      send_pair(16'hA000, 16'hAFFF, 1'b1);
      send_pair(16'h0000, 16'hFFFF, 1'b1);   // untagged: last good sample
      send_pair(16'hB123, 16'h9FFF, 1'b1);
      send_pair(16'hAFFF, 16'h0000, 1'b0);
      send_pair(16'hA7D0, 16'hA830, 1'b1);
      send_pair(16'hA000, 16'hA000, 1'b1);
      wait_idle();

      write_reg(CSR_SPARE_IDX, 12'hFFF);
      write_reg(ascp_pkg::CSR_HEADER_TAG, 12'hFF5);
      csr_chan.valid <= 1'b0;
      send_pair(16'h5ABC, 16'hA800, 1'b1);
      send_pair(16'h5800, 16'h5FFF, 1'b1);
      send_pair(16'h57FF, 16'h5801, 1'b1);
      wait_idle();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin mid = 12'd2048; lim = 12'd700;  tag = 4'hA; end
            1: begin mid = 12'd0;    lim = 12'd0;    tag = 4'h0; end
            2: begin mid = 12'd4095; lim = 12'd4095; tag = 4'hF; end
            3: begin mid = 12'd0;    lim = 12'd4095; tag = TAG_W'($urandom); end
            4: begin mid = 12'd4095; lim = 12'd0;    tag = TAG_W'($urandom); end
            default: begin
               mid = SAMPLE_W'($urandom);
               lim = SAMPLE_W'($urandom_range(0, 1500));
               tag = TAG_W'($urandom);
            end
         endcase
         write_settings(mid, lim, tag);
         req_idle_on = $urandom_range(0, 3) != 0;
         rsp_idle_on = $urandom_range(0, 3) != 0;
         if (phase == 5) begin
            // long result stall with the sender flat out: pipe fills, input backs up
            req_idle_on  = 1'b0;
            stall_cycles = LONG_STALL;
         end
         recorded = 0;
         while (recorded < PHASE_PAIRS) begin
            rec = $urandom_range(0, 9) != 0;
            send_pair(make_word(sb.midpoint, sb.dev_limit, sb.header_tag),
                      make_word(sb.midpoint, sb.dev_limit, sb.header_tag), rec);
            if (rec) recorded++;
         end
         wait_idle();
      end

      $display("Run covered %0d recording pairs and %0d ignored pairs,",
               sb.recorded_pairs, sb.ignored_pairs);
      $display("%0d results checked, %0d register writes, %0d mismatches.",
               sb.checked, sb.reg_writes, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_pairs.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/ascp_pkg.sv
src/ascp_req_if.sv
src/ascp_rsp_if.sv
src/ascp_csr_if.sv
src/audio_sample_cleanup_packer_top.sv
bench/testbench.sv
